FILE: hw/rtl/tbc_pkg.sv
// Shared types, constants and the round mixing function of the TEA cipher.
// Used by tbc_keys, tbc_cell and tea_block_cipher_top; depends on nothing.
package tbc_pkg;

  localparam int unsigned WORD_W       = 32;
  localparam int unsigned BLOCK_W      = 2 * WORD_W;
  localparam int unsigned KEY_WORDS    = 4;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned ROUND_COUNT_DEF = 32;

  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;

  // Key register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] KEY_IDX_0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] KEY_IDX_1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] KEY_IDX_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] KEY_IDX_3 = 2'd3;

  // Operation codes carried by the cmd bit
  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [KEY_WORDS-1:0] key_t;

  // What one cell hands to the next
  typedef struct packed {
    logic  valid;
    logic  cmd;
    word_t y;
    word_t z;
  } stage_t;

  // TEA mixing term
  function automatic word_t tea_mix(word_t v, word_t sum, word_t ka, word_t kb);
    tea_mix = ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
  endfunction

endpackage

FILE: hw/rtl/tbc_keys.sv
// Key register file: four 32-bit key words written through the config port.
// Depends on tbc_pkg.
module tbc_keys
  import tbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [WORD_W-1:0]    cfg_wdata,
  output key_t                 key
);

  key_t key_r;

  // Decode the index and load the selected word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        KEY_IDX_0: key_r[0] <= cfg_wdata;
        KEY_IDX_1: key_r[1] <= cfg_wdata;
        KEY_IDX_2: key_r[2] <= cfg_wdata;
        KEY_IDX_3: key_r[3] <= cfg_wdata;
        default:   key_r    <= key_r;
      endcase
    end
  end

  assign key = key_r;

endmodule

FILE: hw/rtl/tbc_cell.sv
// One half-round cell of the TEA chain: updates one half of the block and
// registers the result for the next cell. Depends on tbc_pkg.
module tbc_cell
  import tbc_pkg::*;
#(
  parameter int unsigned ROUND_COUNT = ROUND_COUNT_DEF,
  parameter int unsigned STEP        = 0
)
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  key_t   key,
  input  stage_t din,
  output stage_t dout
);

  // Round sums fixed at elaboration for both directions
  localparam int unsigned RND = STEP / 2;
  localparam logic [63:0] ENC_PROD = 64'(RND + 1) * 64'(TEA_DELTA);
  localparam logic [63:0] DEC_PROD = 64'(ROUND_COUNT - RND) * 64'(TEA_DELTA);
  localparam word_t ENC_SUM = ENC_PROD[WORD_W-1:0];
  localparam word_t DEC_SUM = DEC_PROD[WORD_W-1:0];
  localparam logic  EVEN    = ((STEP % 2) == 0);

  logic   upd_y;
  word_t  src;
  word_t  old;
  word_t  sum;
  word_t  ka;
  word_t  kb;
  word_t  mixv;
  word_t  newv;
  stage_t data_r;
  stage_t data_nxt;

  // Encryption updates y on even steps, decryption on odd steps
  always_comb begin
    upd_y = (din.cmd == CMD_DECRYPT) ? !EVEN : EVEN;
    sum   = (din.cmd == CMD_DECRYPT) ? DEC_SUM : ENC_SUM;
    src   = upd_y ? din.z : din.y;
    old   = upd_y ? din.y : din.z;
    ka    = upd_y ? key[0] : key[2];
    kb    = upd_y ? key[1] : key[3];
    mixv  = tea_mix(src, sum, ka, kb);
    newv  = (din.cmd == CMD_DECRYPT) ? (old - mixv) : (old + mixv);
    data_nxt = din;
    if (upd_y) begin
      data_nxt.y = newv;
    end else begin
      data_nxt.z = newv;
    end
  end

  // Advance when the chain moves, hold otherwise
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r.valid <= 1'b0;
    end else if (en) begin
      data_r <= data_nxt;
    end
  end

  assign dout = data_r;

endmodule

FILE: hw/rtl/tea_block_cipher_top.sv
// TEA block cipher (ECB) top level: key registers and the chain of cells.
// Depends on tbc_pkg, tbc_keys and tbc_cell.
//
// Usage:
//   Load the four key words through cfg_we / cfg_idx / cfg_wdata while the
//   block is idle; each write takes effect at the clock edge it is given.
//   Present a block on in_block_in with in_cmd (0 encrypt, 1 decrypt) and
//   in_valid; a transfer happens when in_valid and in_ready are both high.
//   Results leave on out_block_out with out_valid / out_ready, in order.
// Pipeline and throughput:
//   The block runs through 2 * ROUND_COUNT half-round cells, one register
//   each; the last cell register is the output register. One block is
//   taken every cycle while the receiver takes results or the output
//   register is empty.
// Stall:
//   When a result waits and out_ready is low, the whole chain holds and
//   in_ready drops; any empty slot in the output register lets it advance.
// Reset:
//   rst_n (synchronous, active low) clears all cell valid flags and the
//   key words to zero.
module tea_block_cipher_top
  import tbc_pkg::*;
#(
  parameter int unsigned ROUND_COUNT = ROUND_COUNT_DEF
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [WORD_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_cmd,
  input  logic [BLOCK_W-1:0]   in_block_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BLOCK_W-1:0]   out_block_out
);

  localparam int unsigned CELLS = 2 * ROUND_COUNT;

  key_t   key;
  logic   chain_en;
  stage_t stg [CELLS+1];

  tbc_keys u_keys (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .key       (key)
  );

  // Move the chain whenever the output slot is free or being taken
  assign chain_en = !stg[CELLS].valid || out_ready;
  assign in_ready = chain_en;

  // Feed the first cell from the input channel
  assign stg[0] = '{valid: in_valid,
                    cmd:   in_cmd,
                    y:     in_block_in[BLOCK_W-1:WORD_W],
                    z:     in_block_in[WORD_W-1:0]};

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    tbc_cell #(
      .ROUND_COUNT (ROUND_COUNT),
      .STEP        (i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (chain_en),
      .key   (key),
      .din   (stg[i]),
      .dout  (stg[i+1])
    );
  end

  assign out_valid     = stg[CELLS].valid;
  assign out_block_out = {stg[CELLS].y, stg[CELLS].z};

  // An accepted block enters the first cell
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> stg[1].valid)
    else $error("accepted block did not enter the chain");

  // A held chain keeps the first cell unchanged
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> $stable(stg[1]))
    else $error("first cell changed while the chain was held");

  // Reset leaves no result pending
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

FILE: tb/tea_block_cipher_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for tea_block_cipher_top: random and directed blocks, both commands.
// Depends on tbc_pkg and the tea_block_cipher_top RTL; predicts each result block internally.
module tea_block_cipher_top_tb;
  import tbc_pkg::*;

  localparam int unsigned LATENCY = 2 * ROUND_COUNT_DEF;

  // Receiver stall modes
  localparam int RX_STREAM = 0;
  localparam int RX_BUSY   = 1;
  localparam int RX_SPARSE = 2;

  localparam logic [BLOCK_W-1:0] CORNER_BLOCKS [8] = '{
    64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
    64'h8000_0000_0000_0001, 64'h0000_0001_8000_0000,
    64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF,
    64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555
  };

  typedef struct packed {
    logic               cmd;
    logic [BLOCK_W-1:0] blk;
  } tea_req_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [WORD_W-1:0]    cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_cmd = CMD_ENCRYPT;
  logic [BLOCK_W-1:0]   in_block_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [BLOCK_W-1:0]   out_block_out;

  tea_req_t           block_req_q[$];
  logic [BLOCK_W-1:0] cipher_exp_q[$];
  word_t              key_shadow[KEY_WORDS];
  int                 mismatch_count = 0;
  int                 blocks_seen = 0;
  int                 gap_left = 0;
  int                 burst_left = 0;

  tea_block_cipher_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_block_in  (in_block_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_block_out(out_block_out)
  );

  always #5 clk = ~clk;

  // One half-round mixing term
  function automatic word_t feistel_term(word_t v, word_t sum, word_t ka, word_t kb);
    word_t left;
    word_t right;
    left  = (v << 4) + ka;
    right = (v >> 5) + kb;
    return left ^ (v + sum) ^ right;
  endfunction

  // Full 32-round cipher under the shadow key
  function automatic logic [BLOCK_W-1:0] tea_cipher(logic cmd, logic [BLOCK_W-1:0] blk);
    word_t y;
    word_t z;
    word_t sum;
    y = blk[BLOCK_W-1:WORD_W];
    z = blk[WORD_W-1:0];
    if (cmd == CMD_ENCRYPT) begin
      sum = '0;
      for (int r = 0; r < ROUND_COUNT_DEF; r++) begin
        sum = sum + TEA_DELTA;
        y = y + feistel_term(z, sum, key_shadow[0], key_shadow[1]);
        z = z + feistel_term(y, sum, key_shadow[2], key_shadow[3]);
      end
    end else begin
      sum = TEA_DELTA * ROUND_COUNT_DEF;
      for (int r = 0; r < ROUND_COUNT_DEF; r++) begin
        z = z - feistel_term(y, sum, key_shadow[2], key_shadow[3]);
        y = y - feistel_term(z, sum, key_shadow[0], key_shadow[1]);
        sum = sum - TEA_DELTA;
      end
    end
    return {y, z};
  endfunction

  function automatic logic [BLOCK_W-1:0] random_block();
    case ($urandom_range(0, 7))
      0: return {32'h0000_0000, 32'($urandom)};
      1: return {32'($urandom), 32'hFFFF_FFFF};
      default: return {32'($urandom), 32'($urandom)};
    endcase
  endfunction

  task automatic queue_block(logic cmd, logic [BLOCK_W-1:0] blk);
    tea_req_t req;
    req.cmd = cmd;
    req.blk = blk;
    block_req_q.push_back(req);
  endtask

  // Encrypt a block, then decrypt its ciphertext
  task automatic queue_round_trip(logic [BLOCK_W-1:0] blk);
    queue_block(CMD_ENCRYPT, blk);
    queue_block(CMD_DECRYPT, tea_cipher(CMD_ENCRYPT, blk));
  endtask

  task automatic queue_random(int count);
    int n;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) < 3) begin
        queue_round_trip(random_block());
        n += 2;
      end else begin
        queue_block($urandom_range(0, 1) ? CMD_DECRYPT : CMD_ENCRYPT, random_block());
        n++;
      end
    end
  endtask

  task automatic write_key(logic [CFG_IDX_W-1:0] idx, word_t val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    key_shadow[idx] = val;
  endtask

  task automatic load_key(word_t k0, word_t k1, word_t k2, word_t k3);
    write_key(KEY_IDX_0, k0);
    write_key(KEY_IDX_1, k1);
    write_key(KEY_IDX_2, k2);
    write_key(KEY_IDX_3, k3);
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  // Hold until every queued block is sent and every result is back
  task automatic drain();
    do @(negedge clk);
    while (block_req_q.size() != 0 || in_valid || cipher_exp_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // Stimulus: keys per phase, directed corners first, then random blocks
  initial begin
    foreach (key_shadow[i]) key_shadow[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Key left at its reset value
    foreach (CORNER_BLOCKS[i]) begin
      queue_block(CMD_ENCRYPT, CORNER_BLOCKS[i]);
      queue_block(CMD_DECRYPT, CORNER_BLOCKS[i]);
    end
    for (int i = 0; i < 4; i++) queue_round_trip(CORNER_BLOCKS[i]);
    drain();

    load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_round_trip(CORNER_BLOCKS[0]);
    queue_round_trip(CORNER_BLOCKS[1]);
    queue_random(150);
    drain();

    load_key(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210);
    queue_random(150);
    drain();

    load_key(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    queue_random(150);
    drain();

    for (int p = 0; p < 5; p++) begin
      load_key($urandom, $urandom, $urandom, $urandom);
      queue_random(190);
      drain();
    end

    // Let any stray result show up before the verdict
    repeat (LATENCY + 16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tea_block_cipher_top_tb: PASS");
    end else begin
      $display("tea_block_cipher_top_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tea_block_cipher_top_tb: FAIL");
    $finish;
  end

  // Driver: send queued blocks in bursts with gaps; record the expected result per transfer
  always @(posedge clk) begin : block_driver
    tea_req_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) cipher_exp_q.push_back(tea_cipher(in_cmd, in_block_in));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (block_req_q.size() != 0) begin
          req = block_req_q.pop_front();
          in_valid    <= 1'b1;
          in_cmd      <= req.cmd;
          in_block_in <= req.blk;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(0, 20);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer and drive the receiver's stall pattern
  always @(posedge clk) begin : result_monitor
    logic [BLOCK_W-1:0] expected;
    int mode;
    int seg_left;
    int hold_left;
    bit long_hold_done;
    if (!rst_n) begin
      out_ready <= 1'b0;
      mode = RX_STREAM;
      seg_left = 0;
      hold_left = 0;
      long_hold_done = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        blocks_seen++;
        if (cipher_exp_q.size() == 0) begin
          mismatch_count++;
          $error("block_out: no result expected, got %h", out_block_out);
        end else begin
          expected = cipher_exp_q.pop_front();
          if (out_block_out !== expected) begin
            mismatch_count++;
            $error("block_out mismatch: expected %h, got %h", expected, out_block_out);
          end
        end
      end

      // Long hold-off once the sender has plenty queued, so the chain fills
      if (!long_hold_done && blocks_seen > 60 && block_req_q.size() > 50) begin
        long_hold_done = 1'b1;
        hold_left = 300;
      end else if (hold_left == 0 && $urandom_range(0, 1499) == 0) begin
        hold_left = $urandom_range(100, 200);
      end

      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(RX_STREAM, RX_SPARSE);
          seg_left = $urandom_range(8, 120);
        end
        seg_left--;
        case (mode)
          RX_STREAM: out_ready <= 1'b1;
          RX_BUSY:   out_ready <= ($urandom_range(0, 9) < 7);
          default:   out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

endmodule
